>>> rtl/square_matrix_multiply_top_macros.svh
// Assertion macros of the square matrix multiplier checker.
`ifndef SQUARE_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SMM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("square matrix multiply check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SMM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("square matrix multiply check failed");

`endif

>>> rtl/smm_pkg.sv
// Shared types and constants of the square matrix multiplier.
`default_nettype none
package smm_pkg;

  localparam int DIM_DEF       = 8;
  localparam int ELEM_BITS_DEF = 16;

  localparam int FUNC_W = 2;
  localparam int IDX_W  = 3;
  localparam int VAL_W  = 16;
  localparam int SIZE_W = 4;
  localparam int PROD_W = 35;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_A   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MULTIPLY = 2'd2;

  typedef struct packed {
    logic vld;
    logic first;
    logic lastk;
  } mac_ctl_t;

endpackage
`default_nettype wire

>>> rtl/smm_if.sv
// Channel interfaces of the square matrix multiplier.
`default_nettype none
interface smm_in_if;
  logic                              valid;
  logic                              ready;
  logic [smm_pkg::FUNC_W-1:0]        func;
  logic [smm_pkg::IDX_W-1:0]         row;
  logic [smm_pkg::IDX_W-1:0]         col;
  logic signed [smm_pkg::VAL_W-1:0]  value;

  modport source (output valid, output func, output row, output col, output value,
                  input ready);
  modport sink (input valid, input func, input row, input col, input value,
                output ready);
endinterface

interface smm_out_if;
  logic                               valid;
  logic                               ready;
  logic [smm_pkg::IDX_W-1:0]          out_row;
  logic [smm_pkg::IDX_W-1:0]          out_col;
  logic signed [smm_pkg::PROD_W-1:0]  product;
  logic                               last;

  modport source (output valid, output out_row, output out_col, output product,
                  output last, input ready);
  modport sink (input valid, input out_row, input out_col, input product,
                input last, output ready);
endinterface

interface smm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [smm_pkg::SIZE_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/smm_mem.sv
// Single-write, single-read matrix element memory with registered read data.
`default_nettype none
module smm_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata_r
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/smm_mac.sv
// Shared multiply-accumulate unit with a control tag pipeline.
`default_nettype none
module smm_mac #(
  parameter int ELEM_BITS = smm_pkg::ELEM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  smm_pkg::mac_ctl_t                 ctl,
  input  logic [ELEM_BITS-1:0]              a_data,
  input  logic [ELEM_BITS-1:0]              b_data,
  output logic                              done,
  output logic signed [smm_pkg::PROD_W-1:0] acc
);

  smm_pkg::mac_ctl_t                 ctl1_r;
  smm_pkg::mac_ctl_t                 ctl2_r;
  logic                              done_r;
  logic signed [2*ELEM_BITS-1:0]     prod_r;
  logic signed [smm_pkg::PROD_W-1:0] prod_ext;
  logic signed [smm_pkg::PROD_W-1:0] acc_r;

  assign prod_ext = smm_pkg::PROD_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      done_r <= ctl2_r.vld && ctl2_r.lastk;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(a_data) * $signed(b_data);
    if (ctl2_r.vld) begin
      acc_r <= ctl2_r.first ? prod_ext : acc_r + prod_ext;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule
`default_nettype wire

>>> rtl/square_matrix_multiply_top.sv
// Top level of the square matrix multiplier: sequencer, storage and MAC.
//
// Input channel in_ch carries one command per transfer: func selects a load of
// an element of A, a load of an element of B, or a multiply. Loads whose row or
// col is not below the current size are dropped. After a load the block is
// ready again in the next cycle.
// A multiply walks all n*n elements of C = A*B in row-major order. For each
// element the sequencer issues n reads, one for each k, into the single
// multiply-accumulate unit; after the memory read, multiply and accumulate
// registers the element is offered on out_ch with last set on the final
// element. in_ch is not ready while a multiply is in progress.
// When the receiver stalls, the offered element holds and the walk pauses.
// The user must keep the block idle whenever cfg_ch writes the size register;
// the block itself does not enforce this, and cfg_ch is always ready. Reset
// sets the size to eight and returns the sequencer to idle; the matrix
// contents are undefined until loaded.
`default_nettype none
module square_matrix_multiply_top #(
  parameter int DIM       = smm_pkg::DIM_DEF,
  parameter int ELEM_BITS = smm_pkg::ELEM_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  smm_in_if.sink           in_ch,
  smm_out_if.source        out_ch,
  smm_cfg_if.sink          cfg_ch
);

  localparam int AW = $clog2(DIM * DIM);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [smm_pkg::SIZE_W-1:0]       size_r;
  logic [smm_pkg::SIZE_W-1:0]       n_now;
  logic [smm_pkg::SIZE_W-1:0]       nm1;
  logic [smm_pkg::IDX_W-1:0]        i_r, i_nxt;
  logic [smm_pkg::IDX_W-1:0]        j_r, j_nxt;
  logic [smm_pkg::IDX_W-1:0]        k_r, k_nxt;
  logic                             in_fire;
  logic                             load_ok;
  logic                             we_a, we_b;
  logic [AW-1:0]                    waddr;
  logic [ELEM_BITS-1:0]             wdata;
  logic [AW-1:0]                    raddr_a, raddr_b;
  logic [ELEM_BITS-1:0]             rdata_a, rdata_b;
  logic                             i_last, j_last, k_last;
  logic                             issue;
  smm_pkg::mac_ctl_t                mac_ctl;
  logic                             mac_done;
  logic signed [smm_pkg::PROD_W-1:0] mac_acc;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= smm_pkg::SIZE_RESET;
    end else if (cfg_ch.valid) begin
      size_r <= cfg_ch.data;
    end
  end

  always_comb begin
    if (size_r == '0) begin
      n_now = smm_pkg::SIZE_W'(1);
    end else if (size_r > smm_pkg::SIZE_W'(DIM)) begin
      n_now = smm_pkg::SIZE_W'(DIM);
    end else begin
      n_now = size_r;
    end
  end

  assign nm1 = n_now - smm_pkg::SIZE_W'(1);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_ok     = ({1'b0, in_ch.row} < n_now) && ({1'b0, in_ch.col} < n_now);
  assign we_a        = in_fire && (in_ch.func == smm_pkg::FUNC_LOAD_A) && load_ok;
  assign we_b        = in_fire && (in_ch.func == smm_pkg::FUNC_LOAD_B) && load_ok;
  assign waddr       = AW'(in_ch.row * DIM + in_ch.col);
  assign wdata       = ELEM_BITS'(in_ch.value);

  assign raddr_a = AW'(i_r * DIM + k_r);
  assign raddr_b = AW'(k_r * DIM + j_r);

  assign i_last = ({1'b0, i_r} == nm1);
  assign j_last = ({1'b0, j_r} == nm1);
  assign k_last = ({1'b0, k_r} == nm1);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    issue     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.func == smm_pkg::FUNC_MULTIPLY)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        issue = 1'b1;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (mac_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ch.ready) begin
          if (i_last && j_last) begin
            state_nxt = S_IDLE;
          end else begin
            if (j_last) begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
            state_nxt = S_RUN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  assign mac_ctl.vld   = issue;
  assign mac_ctl.first = (k_r == '0);
  assign mac_ctl.lastk = k_last;

  smm_mem #(
    .DEPTH (DIM * DIM),
    .AW    (AW),
    .W     (ELEM_BITS)
  ) u_mem_a (
    .clk     (clk),
    .we      (we_a),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr_a),
    .rdata_r (rdata_a)
  );

  smm_mem #(
    .DEPTH (DIM * DIM),
    .AW    (AW),
    .W     (ELEM_BITS)
  ) u_mem_b (
    .clk     (clk),
    .we      (we_b),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr_b),
    .rdata_r (rdata_b)
  );

  smm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_data (rdata_a),
    .b_data (rdata_b),
    .done   (mac_done),
    .acc    (mac_acc)
  );

  assign out_ch.valid   = (state_r == S_EMIT);
  assign out_ch.out_row = i_r;
  assign out_ch.out_col = j_r;
  assign out_ch.product = mac_acc;
  assign out_ch.last    = i_last && j_last;

endmodule
`default_nettype wire

>>> rtl/smm_checker.sv
// Port-level checker of the square matrix multiplier and its bind.
`default_nettype none
`include "square_matrix_multiply_top_macros.svh"
module smm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [smm_pkg::FUNC_W-1:0]        in_func,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_last,
  input logic signed [smm_pkg::PROD_W-1:0] out_product
);

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // A stalled result must hold its value.
  `SMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_product))
  // No command is taken while a result is offered.
  `SMM_ASSERT_IMPL(a_busy_emit, out_valid, !in_ready)
  // The final element ends the multiply.
  `SMM_ASSERT_NEXT(a_last_ends, out_fire && out_last, !out_valid && in_ready)
  // A load or an unused code leaves the block ready in the next cycle.
  `SMM_ASSERT_NEXT(a_load_ready, in_fire && (in_func != smm_pkg::FUNC_MULTIPLY), in_ready)
  // A multiply command makes the block busy in the next cycle.
  `SMM_ASSERT_NEXT(a_mul_busy, in_fire && (in_func == smm_pkg::FUNC_MULTIPLY), !in_ready)

endmodule

bind square_matrix_multiply_top smm_checker u_smm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_func     (in_ch.func),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_last    (out_ch.last),
  .out_product (out_ch.product)
);
`default_nettype wire
